FILE: src/smsgpm_pkg.sv
// Shared types and constants for the stereo mid/side gain, pan and meter block.
`default_nettype none

package smsgpm_pkg;

  // Sample and gain formats.
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int PEAK_W   = 24;

  // Scope ring.
  localparam int SCOPE_DEPTH = 2048;
  localparam int SCOPE_W     = $clog2(SCOPE_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MUTE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_SOLO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_SOLO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCOPE_EN  = 3'd4;

  // Channel layout codes; the unused code behaves like the bypass layout.
  localparam logic [1:0] LAYOUT_STEREO = 2'd0;
  localparam logic [1:0] LAYOUT_MONO   = 2'd1;
  localparam logic [1:0] LAYOUT_BYPASS = 2'd2;

  // Multiplier step selection issued by the controller.
  localparam logic [1:0] SEL_IDLE = 2'd0;
  localparam logic [1:0] SEL_MUL1 = 2'd1;
  localparam logic [1:0] SEL_MUL2 = 2'd2;
  localparam logic [1:0] SEL_MUL3 = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic [1:0] mul_sel;
    logic       commit;
  } cmd_t;

endpackage

`default_nettype wire

FILE: src/smsgpm_ctrl.sv
// Controller state machine that sequences one sample through the datapath.
`default_nettype none

module smsgpm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output smsgpm_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_MUL3 = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.load_in = 1'b0;
    cmd.mul_sel = smsgpm_pkg::SEL_IDLE;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul_sel = smsgpm_pkg::SEL_MUL1;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_sel = smsgpm_pkg::SEL_MUL2;
        state_nxt   = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul_sel = smsgpm_pkg::SEL_MUL3;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten while held");

  // An accepted sample always starts the multiply sequence next.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MUL1))
    else $error("accepted sample did not start processing");

  // A committed result is offered in the following cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  // The multiply steps run back to back after the accept.
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_sel == smsgpm_pkg::SEL_MUL1) |=> (cmd.mul_sel == smsgpm_pkg::SEL_MUL2))
    else $error("multiply sequence broken");

endmodule

`default_nettype wire

FILE: src/smsgpm_dp.sv
// Datapath: configuration, two shared multipliers, solo logic, meters and scope index.
`default_nettype none

module smsgpm_dp (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire smsgpm_pkg::cmd_t                         cmd,
  input  wire logic                                     cfg_we,
  input  wire logic [smsgpm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [smsgpm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic signed [23:0]                       in_left_in,
  input  wire logic signed [23:0]                       in_right_in,
  input  wire logic [15:0]                              in_mid_gain,
  input  wire logic [15:0]                              in_side_gain,
  input  wire logic [15:0]                              in_volume_base,
  input  wire logic signed [16:0]                       in_volume_mod,
  input  wire logic signed [15:0]                       in_pan_base,
  input  wire logic signed [15:0]                       in_pan_mod,
  input  wire logic                                     in_last_in_block,
  output logic signed [23:0]                            out_left_out,
  output logic signed [23:0]                            out_right_out,
  output logic signed [23:0]                            out_scope_left,
  output logic signed [23:0]                            out_scope_right,
  output logic [smsgpm_pkg::SCOPE_W-1:0]                out_scope_index,
  output logic                                          out_scope_valid,
  output logic [smsgpm_pkg::PEAK_W-1:0]                 out_mid_peak,
  output logic [smsgpm_pkg::PEAK_W-1:0]                 out_side_peak,
  output logic [smsgpm_pkg::PEAK_W-1:0]                 out_left_peak,
  output logic [smsgpm_pkg::PEAK_W-1:0]                 out_right_peak,
  output logic                                          out_block_done
);

  function automatic logic signed [23:0] sat24(input logic signed [54:0] x);
    logic signed [23:0] r;
    if (x > 55'sd8388607) begin
      r = 24'sh7fffff;
    end else if (x < -55'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] rnd_sat14(input logic signed [54:0] p);
    logic signed [54:0] t;
    t = (p + 55'sd8192) >>> 14;
    return sat24(t);
  endfunction

  function automatic logic signed [23:0] rnd_sat28(input logic signed [54:0] p);
    logic signed [54:0] t;
    t = (p + 55'sd134217728) >>> 28;
    return sat24(t);
  endfunction

  function automatic logic [23:0] mag24(input logic signed [23:0] x);
    logic [23:0] r;
    r = x[23] ? (~x + 24'd1) : x;
    return r;
  endfunction

  function automatic logic [23:0] max24(input logic [23:0] a, input logic [23:0] b);
    return (a > b) ? a : b;
  endfunction

  // Configuration registers.
  logic       mute_r;
  logic [1:0] layout_r;
  logic       mid_solo_r;
  logic       side_solo_r;
  logic       scope_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r      <= 1'b0;
      layout_r    <= smsgpm_pkg::LAYOUT_STEREO;
      mid_solo_r  <= 1'b0;
      side_solo_r <= 1'b0;
      scope_en_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smsgpm_pkg::CFG_MUTE:      mute_r      <= cfg_data[0];
        smsgpm_pkg::CFG_LAYOUT:    layout_r    <= cfg_data[1:0];
        smsgpm_pkg::CFG_MID_SOLO:  mid_solo_r  <= cfg_data[0];
        smsgpm_pkg::CFG_SIDE_SOLO: side_solo_r <= cfg_data[0];
        smsgpm_pkg::CFG_SCOPE_EN:  scope_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic is_gain;
  logic is_mono;
  assign is_gain = (layout_r == smsgpm_pkg::LAYOUT_STEREO);
  assign is_mono = (layout_r == smsgpm_pkg::LAYOUT_MONO);

  // Input capture, with the volume and pan clamps and the mid/side split done on the way in.
  logic signed [17:0] vsum;
  logic [15:0]        vol_c;
  logic signed [16:0] psum;
  logic signed [16:0] pan_c;
  logic signed [17:0] gl_full;
  logic signed [17:0] gr_full;
  logic [14:0]        gl_c;
  logic [14:0]        gr_c;
  logic signed [24:0] lr_sum;
  logic signed [24:0] lr_dif;

  always_comb begin
    vsum = $signed({2'b00, in_volume_base}) + $signed({in_volume_mod[16], in_volume_mod});
    if (vsum < 18'sd0) begin
      vol_c = 16'd0;
    end else if (vsum > 18'sd32768) begin
      vol_c = 16'd32768;
    end else begin
      vol_c = vsum[15:0];
    end
    psum = $signed({in_pan_base[15], in_pan_base}) + $signed({in_pan_mod[15], in_pan_mod});
    if (psum > 17'sd16384) begin
      pan_c = 17'sd16384;
    end else if (psum < -17'sd16384) begin
      pan_c = -17'sd16384;
    end else begin
      pan_c = psum;
    end
    gl_full = 18'sd16384 - $signed({pan_c[16], pan_c});
    gr_full = 18'sd16384 + $signed({pan_c[16], pan_c});
    gl_c = (gl_full > 18'sd16384) ? 15'd16384 : gl_full[14:0];
    gr_c = (gr_full > 18'sd16384) ? 15'd16384 : gr_full[14:0];
    lr_sum = $signed({in_left_in[23], in_left_in}) + $signed({in_right_in[23], in_right_in});
    lr_dif = $signed({in_left_in[23], in_left_in}) - $signed({in_right_in[23], in_right_in});
  end

  logic signed [23:0] l_r;
  logic signed [23:0] r_r;
  logic signed [23:0] mid_r;
  logic signed [23:0] side_r;
  logic [15:0]        gm_r;
  logic [15:0]        gs_r;
  logic [15:0]        vol_r;
  logic [14:0]        gl_r;
  logic [14:0]        gr_r;
  logic               last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      l_r    <= in_left_in;
      r_r    <= in_right_in;
      mid_r  <= lr_sum[24:1];
      side_r <= lr_dif[24:1];
      gm_r   <= in_mid_gain;
      gs_r   <= in_side_gain;
      vol_r  <= vol_c;
      gl_r   <= gl_c;
      gr_r   <= gr_c;
      last_r <= in_last_in_block;
    end
  end

  // Two shared multipliers, each followed by a product register. The pan
  // times volume product reaches 2^29 at full volume and hard pan, so the
  // second operand carries thirty magnitude bits.
  logic signed [24:0] a0;
  logic signed [24:0] a1;
  logic signed [30:0] b0;
  logic signed [30:0] b1;
  logic signed [54:0] prod0;
  logic signed [54:0] prod1;
  logic signed [54:0] p0_r;
  logic signed [54:0] p1_r;
  logic signed [23:0] mg_r;
  logic signed [23:0] sg_r;

  always_comb begin
    a0 = '0;
    b0 = '0;
    a1 = '0;
    b1 = '0;
    case (cmd.mul_sel)
      smsgpm_pkg::SEL_MUL1: begin
        if (is_mono) begin
          a0 = {l_r[23], l_r};
          b0 = {15'd0, vol_r};
        end else begin
          a0 = {mid_r[23], mid_r};
          b0 = {15'd0, gm_r};
        end
        a1 = {side_r[23], side_r};
        b1 = {15'd0, gs_r};
      end
      smsgpm_pkg::SEL_MUL2: begin
        a0 = {10'd0, gl_r};
        b0 = {15'd0, vol_r};
        a1 = {10'd0, gr_r};
        b1 = {15'd0, vol_r};
      end
      smsgpm_pkg::SEL_MUL3: begin
        a0 = $signed({mg_r[23], mg_r}) + $signed({sg_r[23], sg_r});
        b0 = {1'b0, p0_r[29:0]};
        a1 = $signed({mg_r[23], mg_r}) - $signed({sg_r[23], sg_r});
        b1 = {1'b0, p1_r[29:0]};
      end
      default: ;
    endcase
  end

  assign prod0 = a0 * b0;
  assign prod1 = a1 * b1;

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != smsgpm_pkg::SEL_IDLE) begin
      p0_r <= prod0;
      p1_r <= prod1;
    end
    if (cmd.mul_sel == smsgpm_pkg::SEL_MUL2) begin
      mg_r <= rnd_sat14(p0_r);
      sg_r <= rnd_sat14(p1_r);
    end
  end

  // Final stage: rebuild, solo and mute.
  logic signed [23:0] pre_l;
  logic signed [23:0] pre_r;
  logic signed [24:0] solo_sum;
  logic signed [23:0] solo_m;
  logic signed [24:0] dl;
  logic signed [24:0] dr;
  logic signed [23:0] lo;
  logic signed [23:0] ro;
  logic               scope_hit;

  always_comb begin
    if (is_gain) begin
      pre_l = rnd_sat28(p0_r);
      pre_r = rnd_sat28(p1_r);
    end else begin
      pre_l = l_r;
      pre_r = r_r;
    end
    solo_sum = $signed({pre_l[23], pre_l}) + $signed({pre_r[23], pre_r});
    solo_m   = solo_sum[24:1];
    dl       = $signed({pre_l[23], pre_l}) - $signed({solo_m[23], solo_m});
    dr       = $signed({pre_r[23], pre_r}) - $signed({solo_m[23], solo_m});
    if (mute_r) begin
      lo = '0;
      ro = '0;
    end else if (is_mono) begin
      lo = mg_r;
      ro = mg_r;
    end else if (mid_solo_r) begin
      lo = solo_m;
      ro = solo_m;
    end else if (side_solo_r) begin
      lo = sat24(55'(dl));
      ro = sat24(55'(dr));
    end else begin
      lo = pre_l;
      ro = pre_r;
    end
    scope_hit = !mute_r && is_gain && scope_en_r;
  end

  // Meters and scope position.
  logic [23:0]                    run_r [4];
  logic [23:0]                    rep_r [4];
  logic [23:0]                    run_upd [4];
  logic [smsgpm_pkg::SCOPE_W-1:0] pos_r;

  always_comb begin
    run_upd[0] = (!mute_r && is_gain) ? max24(run_r[0], mag24(mg_r)) : run_r[0];
    run_upd[1] = (!mute_r && is_gain) ? max24(run_r[1], mag24(sg_r)) : run_r[1];
    run_upd[2] = !mute_r ? max24(run_r[2], mag24(lo)) : run_r[2];
    run_upd[3] = !mute_r ? max24(run_r[3], mag24(ro)) : run_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        run_r[i] <= '0;
        rep_r[i] <= '0;
      end
      pos_r <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < 4; i++) begin
        run_r[i] <= last_r ? 24'd0 : run_upd[i];
      end
      if (last_r && !mute_r) begin
        if (is_gain) begin
          rep_r[0] <= run_upd[0];
          rep_r[1] <= run_upd[1];
        end
        rep_r[2] <= run_upd[2];
        rep_r[3] <= is_mono ? run_upd[2] : run_upd[3];
      end
      if (scope_hit) begin
        pos_r <= (pos_r == smsgpm_pkg::SCOPE_W'(smsgpm_pkg::SCOPE_DEPTH - 1)) ?
                 '0 : pos_r + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_left_out    <= lo;
      out_right_out   <= ro;
      out_scope_left  <= scope_hit ? pre_l : 24'sd0;
      out_scope_right <= scope_hit ? pre_r : 24'sd0;
      out_scope_index <= scope_hit ? pos_r : '0;
      out_scope_valid <= scope_hit;
      out_block_done  <= last_r && !mute_r;
    end
  end

  assign out_mid_peak   = rep_r[0];
  assign out_side_peak  = rep_r[1];
  assign out_left_peak  = rep_r[2];
  assign out_right_peak = rep_r[3];

endmodule

`default_nettype wire

FILE: src/stereo_mid_side_gain_pan_meter.sv
// Top level of the stereo mid/side gain, volume, pan and peak meter block.
`default_nettype none

// This block processes one stereo sample per input transaction and returns
// one result transaction for it. A sample is first accepted and captured,
// then makes three passes through a pair of shared multipliers (mid/side
// gain or, in the mono layout, volume; pan times volume; and the final
// rebuild scaling), and ends in a final step for solo, mute, metering and
// the result write. A new sample is accepted only once the previous one has
// left the final step. The result sits in an output register, so the next
// sample is accepted while a finished result still waits for the consumer;
// processing stalls only at the final step if the previous result has not
// been taken. Samples are Q1.23, gains and volume are Q2.14 with 16384 as
// unity, and pan is Q2.14. The peak fields always show the last reported
// block peaks; they change on the transaction that carries block_done.
// Configuration writes are taken in any cycle, but should only be issued
// while no sample is in flight. The scope index wraps over a ring of 2048
// positions and advances only when scope_valid is set.
module stereo_mid_side_gain_pan_meter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration write channel.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [smsgpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [smsgpm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input sample channel.
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [23:0]                  in_left_in,
  input  wire logic signed [23:0]                  in_right_in,
  input  wire logic [15:0]                         in_mid_gain,
  input  wire logic [15:0]                         in_side_gain,
  input  wire logic [15:0]                         in_volume_base,
  input  wire logic signed [16:0]                  in_volume_mod,
  input  wire logic signed [15:0]                  in_pan_base,
  input  wire logic signed [15:0]                  in_pan_mod,
  input  wire logic                                in_last_in_block,
  // Result channel.
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [23:0]                       out_left_out,
  output logic signed [23:0]                       out_right_out,
  output logic signed [23:0]                       out_scope_left,
  output logic signed [23:0]                       out_scope_right,
  output logic [smsgpm_pkg::SCOPE_W-1:0]           out_scope_index,
  output logic                                     out_scope_valid,
  output logic [smsgpm_pkg::PEAK_W-1:0]            out_mid_peak,
  output logic [smsgpm_pkg::PEAK_W-1:0]            out_side_peak,
  output logic [smsgpm_pkg::PEAK_W-1:0]            out_left_peak,
  output logic [smsgpm_pkg::PEAK_W-1:0]            out_right_peak,
  output logic                                     out_block_done
);

  smsgpm_pkg::cmd_t cmd;

  // Configuration registers are simple flops, so a write is always taken.
  assign cfg_ready = 1'b1;

  // The controller owns the handshakes and steps the datapath.
  smsgpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the arithmetic, the meters and the
  // result register.
  smsgpm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_left_in       (in_left_in),
    .in_right_in      (in_right_in),
    .in_mid_gain      (in_mid_gain),
    .in_side_gain     (in_side_gain),
    .in_volume_base   (in_volume_base),
    .in_volume_mod    (in_volume_mod),
    .in_pan_base      (in_pan_base),
    .in_pan_mod       (in_pan_mod),
    .in_last_in_block (in_last_in_block),
    .out_left_out     (out_left_out),
    .out_right_out    (out_right_out),
    .out_scope_left   (out_scope_left),
    .out_scope_right  (out_scope_right),
    .out_scope_index  (out_scope_index),
    .out_scope_valid  (out_scope_valid),
    .out_mid_peak     (out_mid_peak),
    .out_side_peak    (out_side_peak),
    .out_left_peak    (out_left_peak),
    .out_right_peak   (out_right_peak),
    .out_block_done   (out_block_done)
  );

endmodule

`default_nettype wire
